FILE: rtl/core/positional_list_store_assert.svh
// Assertion macros used by the checker file pls_checker.sv.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int PLS_DEPTH      = 64;
  localparam int PLS_VALUE_BITS = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EDIT   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_KEPT  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_WRITE
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
    logic      rd;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/positional_list_store.sv
// positional_list_store: ordered list of up to DEPTH values, addressed by position.
// Input channel: in_valid_i / in_stall_o carry one request beat (op_i, position_i,
// value_i); op selects insert-after, remove, edit or read.
// Output channel: out_valid_o / out_stall_i carry one result beat per request
// (status_o, read_value_o, count_o).
// Latency: the result is registered and appears the cycle after the request beat.
// Throughput: one request per cycle while no result is stalled. Every element sits
// in a cell of a row; an insert or remove shifts the whole row as the request is
// taken, so row updates never hold the input.
// A read selects the addressed cell and ORs the row onto the result register.
// When the receiver stalls a waiting result, in_stall_o is raised and the result
// holds; a new request is taken in the same cycle the pending result leaves.
// Reset empties the list (count zero) and drops any pending result; cell
// contents are left as they are and only become visible once written.
// Out-of-range positions, inserts into a full list and removal of the only
// element are refused with a status code and no change.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store #(
  parameter int unsigned DEPTH      = pls_pkg::PLS_DEPTH,
  parameter int unsigned VALUE_BITS = pls_pkg::PLS_VALUE_BITS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire [pls_pkg::OP_W-1:0]             op_i,
  input  wire signed [pls_pkg::POS_W-1:0]     position_i,
  input  wire signed [pls_pkg::DATA_W-1:0]    value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [pls_pkg::STATUS_W-1:0]        status_o,
  output logic signed [pls_pkg::DATA_W-1:0]   read_value_o,
  output logic [pls_pkg::COUNT_W-1:0]         count_o
);
  import pls_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  logic [CNT_W-1:0]       held_q, held_d;
  logic                   accept;
  logic signed [CW-1:0]   pos_s, n_s, pos_p1;
  cell_cmd_t              cmd;
  logic [IDX_W-1:0]       target;
  status_e                status;
  logic [VALUE_BITS-1:0]  wval;
  logic [VALUE_BITS-1:0]  cell_val [DEPTH];
  logic [VALUE_BITS-1:0]  cell_rd  [DEPTH];
  logic [VALUE_BITS-1:0]  rd_or;
  logic [DATA_W-1:0]      rd32;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [DATA_W-1:0]      rdata_q;
  logic [COUNT_W-1:0]     count_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_s  = CW'(position_i);
  assign n_s    = CW'(held_q);
  assign pos_p1 = pos_s + CW'(1);

  if (VALUE_BITS >= DATA_W) begin : g_wide
    assign wval = VALUE_BITS'($unsigned(value_i));
    assign rd32 = rd_or[DATA_W-1:0];
  end else begin : g_narrow
    assign wval = value_i[VALUE_BITS-1:0];
    assign rd32 = DATA_W'(rd_or);
  end

  always_comb begin
    status  = ST_OK;
    cmd.act = ACT_HOLD;
    cmd.rd  = 1'b0;
    held_d  = held_q;
    target  = pos_s[IDX_W-1:0];
    if (accept) begin
      unique case (op_e'(op_i))
        OP_INSERT: begin
          target = pos_p1[IDX_W-1:0];
          if (pos_s < -1 || pos_s >= n_s) begin
            status = ST_RANGE;
          end else if (held_q == CNT_W'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            cmd.act = ACT_INSERT;
            held_d  = CNT_W'(held_q + 1'b1);
          end
        end
        OP_REMOVE, OP_EDIT, OP_READ: begin
          if (pos_s < 0 || pos_s >= n_s) begin
            status = ST_RANGE;
          end else if (op_e'(op_i) == OP_REMOVE) begin
            if (held_q == CNT_W'(1)) begin
              status = ST_KEPT;
            end else begin
              cmd.act = ACT_REMOVE;
              held_d  = CNT_W'(held_q - 1'b1);
            end
          end else if (op_e'(op_i) == OP_EDIT) begin
            cmd.act = ACT_WRITE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
        default: status = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [VALUE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[i+1];
    end
    pls_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .target_i (target),
      .wval_i   (wval),
      .left_i   (left),
      .right_i  (right),
      .value_o  (cell_val[i]),
      .read_o   (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      rdata_q  <= rd32;
      count_q  <= COUNT_W'(held_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rdata_q;
  assign count_o      = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/pls_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned IDX        = 0
) (
  input  wire                   clk_i,
  input  pls_pkg::cell_cmd_t    cmd_i,
  input  wire [IDX_W-1:0]       target_i,
  input  wire [VALUE_BITS-1:0]  wval_i,
  input  wire [VALUE_BITS-1:0]  left_i,
  input  wire [VALUE_BITS-1:0]  right_i,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [VALUE_BITS-1:0] read_o
);
  import pls_pkg::*;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  hit, above;

  assign hit   = (target_i == IDX_W'(IDX));
  assign above = (target_i < IDX_W'(IDX));

  always_comb begin
    value_d = value_q;
    case (cmd_i.act)
      ACT_INSERT: begin
        if (hit) begin
          value_d = wval_i;
        end else if (above) begin
          value_d = left_i;
        end
      end
      ACT_REMOVE: begin
        if (hit || above) begin
          value_d = right_i;
        end
      end
      ACT_WRITE: begin
        if (hit) begin
          value_d = wval_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign read_o  = (cmd_i.rd && hit) ? value_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/pls_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_store_assert.svh"

module pls_checker #(
  parameter int unsigned DEPTH = pls_pkg::PLS_DEPTH
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_stall_o,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire [pls_pkg::STATUS_W-1:0]       status_o,
  input wire signed [pls_pkg::DATA_W-1:0]  read_value_o,
  input wire [pls_pkg::COUNT_W-1:0]        count_o
);
  import pls_pkg::*;

  `PLS_ASSERT_NEXT(a_beat_gives_result, in_valid_i && !in_stall_o, out_valid_o,
    "request beat without result")
  `PLS_ASSERT_NOW(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i,
    "input stalled with no waiting result")
  `PLS_ASSERT_NOW(a_count_bound, out_valid_o, count_o <= DEPTH,
    "count above depth")
  `PLS_ASSERT_NOW(a_refused_zero, out_valid_o && status_o != ST_OK, read_value_o == 0,
    "refused request returned data")
  `PLS_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(read_value_o) && $stable(count_o),
    "stalled result changed")

endmodule

bind positional_list_store pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);

`default_nettype wire
